// ----- sv/sbus_pkg.sv -----
// Package for the SBUS gap-framed decoder: request and response payload types,
// register indexes and protocol constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sbus_pkg;
   localparam int BUFFER_DEPTH_DEF = 64;
   localparam int FRAME_BYTES      = 25;
   localparam int CSR_IDX_W        = 3;

   localparam logic [CSR_IDX_W-1:0] REG_GAP_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_LENGTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIGLOST_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NOFRAME_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_THROTTLE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SWITCH_THRESH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ARM_FRAMES     = 3'd6;

   localparam logic       OP_BYTE      = 1'b0;
   localparam logic [15:0] OVERRUN_GAP = 16'hFFFE;
   localparam logic [10:0] CH_MASK     = 11'h7FF;
   localparam logic [11:0] STICK_CENTER = 12'd993;
   localparam logic [11:0] THROTTLE_LOW = 12'd173;
   localparam logic [11:0] THROTTLE_MAX = 12'd1639;
   localparam logic [7:0]  READY_FRAMES = 8'd141;
   localparam logic [7:0]  MIN_FPS      = 8'd30;
   localparam logic [31:0] SECOND_US    = 32'd1000000;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  rx_byte;
      logic [15:0] gap_ticks;
      logic        overrun;
      logic [31:0] now_us;
   } req_type;

   typedef struct packed {
      logic               frame_done;
      logic signed [11:0] roll;
      logic signed [11:0] pitch;
      logic signed [11:0] yaw;
      logic [10:0]        throttle;
      logic [5:0]         aux_switches;
      logic               failsafe;
      logic               normal_mode;
      logic               link_up;
   } rsp_type;
endpackage
`default_nettype wire

// ----- sv/sbus_gap_framed_decoder.sv -----
// A poll or a byte request goes from ST_IDLE straight to ST_RESP, where its response
// is registered; a request that completes a frame first passes through ST_READ, where
// the 25 frame bytes are read one per cycle from the byte ring memory over its single
// read port, and then ST_DEC. One request is handled at a time; a new one is taken as
// soon as the response register is free or being emptied.
// Reset: synchronous, active high; clears control state and loads register
// defaults. The byte ring is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sbus_gap_framed_decoder
   import sbus_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);
   localparam int PW = $clog2(BUFFER_DEPTH);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DEC  = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   // Configuration registers.
   logic [15:0] gap_thr_ff;
   logic [5:0]  frame_len_ff;
   logic [31:0] siglost_lim_ff, noframe_lim_ff;
   logic [10:0] low_thr_ff, sw_thr_ff;
   logic [7:0]  arm_frames_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_thr_ff     <= 16'd9000;
         frame_len_ff   <= 6'd24;
         siglost_lim_ff <= 32'd1000000;
         noframe_lim_ff <= 32'd1000000;
         low_thr_ff     <= 11'd300;
         sw_thr_ff      <= 11'd1600;
         arm_frames_ff  <= 8'd130;
      end else if (csr_valid) begin
         case (csr_index)
            REG_GAP_THRESHOLD: gap_thr_ff     <= csr_wdata[15:0];
            REG_FRAME_LENGTH:  frame_len_ff   <= csr_wdata[5:0];
            REG_SIGLOST_LIMIT: siglost_lim_ff <= csr_wdata;
            REG_NOFRAME_LIMIT: noframe_lim_ff <= csr_wdata;
            REG_LOW_THROTTLE:  low_thr_ff     <= csr_wdata[10:0];
            REG_SWITCH_THRESH: sw_thr_ff      <= csr_wdata[10:0];
            REG_ARM_FRAMES:    arm_frames_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Byte ring: one write port and one registered read port.
   logic [7:0]    ring_mem [BUFFER_DEPTH];
   logic          ring_we;
   logic [PW-1:0] ring_waddr, ring_raddr;
   logic [7:0]    ring_rdata_ff;

   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[ring_waddr] <= req_data.rx_byte;
      ring_rdata_ff <= ring_mem[ring_raddr];
   end

   // Control and decoder state.
   logic [1:0]    state_ff, state_in;
   logic [PW-1:0] wp_ff, fsp_ff;
   logic [7:0]    bss_ff;
   logic [1:0]    fstate_ff;
   logic [31:0]   now_ff;
   logic [4:0]    rcnt_ff;      // read address offset
   logic [4:0]    dcnt_ff;      // index of the byte arriving from the memory
   logic          dvalid_ff;
   logic [7:0]    d_ff [15];    // frame bytes 0..14 (channels)
   logic [7:0]    d23_ff;
   logic [31:0]   sl_since_ff;
   logic          sl_flag_ff, sbfs_ff, armed_ff, ready_ff, done_ff;
   logic [7:0]    arm_cnt_ff, good_cnt_ff, fts_ff, fps_ff;
   logic [31:0]   sec_start_ff, last_ff;
   logic signed [11:0] roll_ff, pitch_ff, yaw_ff;
   logic [10:0]   thr_ff;
   logic [5:0]    aux_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   wire req_fire = req_valid && req_ready;
   wire is_byte  = req_data.opcode == OP_BYTE;

   // Framing on the incoming byte. The ring pointers wrap at the ring depth,
   // which need not be a power of two.
   logic [15:0]   gap_eff;
   logic [7:0]    bss_inc;
   logic          frame_start;
   logic          frame_go;
   logic [PW-1:0] wp_next;
   logic [PW:0]   raddr_sum;
   always_comb begin
      gap_eff     = req_data.overrun ? OVERRUN_GAP : req_data.gap_ticks;
      bss_inc     = (bss_ff == 8'hFF) ? bss_ff : bss_ff + 8'd1;
      frame_start = gap_eff > gap_thr_ff;
      frame_go    = is_byte && !frame_start && bss_inc >= {2'b00, frame_len_ff}
                    && fstate_ff == 2'd0;
      wp_next     = (wp_ff == PW'(BUFFER_DEPTH - 1)) ? '0 : wp_ff + PW'(1);
      raddr_sum   = {1'b0, fsp_ff} + (PW+1)'(rcnt_ff);
      if (raddr_sum >= (PW+1)'(BUFFER_DEPTH))
         ring_raddr = PW'(raddr_sum - (PW+1)'(BUFFER_DEPTH));
      else
         ring_raddr = raddr_sum[PW-1:0];
   end
   assign ring_we    = req_fire && is_byte;
   assign ring_waddr = wp_ff;

   // Channel extraction from the captured bytes.
   logic [10:0] ch [10];
   always_comb begin
      ch[0] = 11'({d_ff[2], d_ff[1]});
      ch[1] = 11'({d_ff[3], d_ff[2]} >> 3);
      ch[2] = 11'({d_ff[5], d_ff[4], d_ff[3]} >> 6);
      ch[3] = 11'({d_ff[6], d_ff[5]} >> 1);
      ch[4] = 11'({d_ff[7], d_ff[6]} >> 4);
      ch[5] = 11'({d_ff[9], d_ff[8], d_ff[7]} >> 7);
      ch[6] = 11'({d_ff[10], d_ff[9]} >> 2);
      ch[7] = 11'({d_ff[11], d_ff[10]} >> 5);
      ch[8] = 11'({d_ff[13], d_ff[12]});
      ch[9] = 11'({d_ff[14], d_ff[13]} >> 3);
   end

   // Decode step arithmetic.
   logic [7:0]  arm_a;
   logic        armed_n;
   logic [7:0]  arm_n;
   logic [12:0] t_raw;
   logic [10:0] t_cl;
   logic [5:0]  aux_n;
   always_comb begin
      arm_a   = arm_cnt_ff;
      armed_n = armed_ff;
      if (!armed_ff) begin
         if (ch[2] < low_thr_ff && arm_a != 8'hFF) arm_a = arm_a + 8'd1;
         if (arm_a > arm_frames_ff) begin
            if (fps_ff > MIN_FPS) armed_n = 1'b1;
            else arm_a = 8'd0;
         end
      end
      arm_n = arm_a;
      t_raw = {2'b00, ch[2]} - {1'b0, THROTTLE_LOW};
      if (t_raw[12]) t_cl = 11'd0;
      else if (t_raw > {1'b0, THROTTLE_MAX}) t_cl = THROTTLE_MAX[10:0];
      else t_cl = t_raw[10:0];
      for (int k = 0; k < 6; k++) aux_n[k] = ch[4 + k] > sw_thr_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_fire) state_in = frame_go ? ST_READ : ST_RESP;
         ST_READ: if (dvalid_ff && dcnt_ff == 5'(FRAME_BYTES - 1)) state_in = ST_DEC;
         ST_DEC:  state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; wp_ff <= '0; fsp_ff <= '0; bss_ff <= '0;
         fstate_ff <= 2'd0; sl_since_ff <= '0; sl_flag_ff <= 1'b0;
         sbfs_ff <= 1'b0; armed_ff <= 1'b0; ready_ff <= 1'b0;
         arm_cnt_ff <= '0; good_cnt_ff <= '0; fts_ff <= '0; fps_ff <= '0;
         sec_start_ff <= '0; last_ff <= '0; roll_ff <= '0; pitch_ff <= '0;
         yaw_ff <= '0; thr_ff <= '0; aux_ff <= '0; rsp_valid_ff <= 1'b0;
         done_ff <= 1'b0; rcnt_ff <= '0; dcnt_ff <= '0; dvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (req_fire) begin
               now_ff  <= req_data.now_us;
               done_ff <= 1'b0;
               if (is_byte) begin
                  wp_ff <= wp_next;
                  if (frame_start) begin
                     fsp_ff <= wp_ff; bss_ff <= '0; fstate_ff <= 2'd0;
                  end else begin
                     bss_ff <= bss_inc;
                     if (frame_go) begin
                        fstate_ff <= 2'd1;
                        rcnt_ff <= '0; dvalid_ff <= 1'b0;
                     end
                  end
               end
            end
            ST_READ: begin
               // Address issued one cycle, data captured the next.
               if (rcnt_ff != 5'(FRAME_BYTES - 1) || !dvalid_ff) begin
                  if (rcnt_ff != 5'(FRAME_BYTES)) rcnt_ff <= rcnt_ff + 5'd1;
               end
               dvalid_ff <= rcnt_ff != 5'(FRAME_BYTES);
               dcnt_ff   <= rcnt_ff;
               if (dvalid_ff) begin
                  if (dcnt_ff < 5'd15) d_ff[dcnt_ff[3:0]] <= ring_rdata_ff;
                  if (dcnt_ff == 5'd23) d23_ff <= ring_rdata_ff;
               end
            end
            ST_DEC: begin
               done_ff <= 1'b1;
               if (d23_ff[2]) begin
                  if (sl_since_ff == 32'd0) begin
                     sl_since_ff <= now_ff;
                  end else if (now_ff - sl_since_ff > siglost_lim_ff) begin
                     sl_flag_ff <= 1'b1;
                  end
               end else begin
                  sl_since_ff <= '0; sl_flag_ff <= 1'b0;
               end
               sbfs_ff    <= d23_ff[3];
               arm_cnt_ff <= arm_n;
               armed_ff   <= armed_n;
               if (armed_n) begin
                  roll_ff  <= $signed({1'b0, ch[0]}) - $signed(STICK_CENTER);
                  pitch_ff <= $signed({1'b0, ch[1]}) - $signed(STICK_CENTER);
                  yaw_ff   <= $signed({1'b0, ch[3]}) - $signed(STICK_CENTER);
                  thr_ff   <= t_cl;
                  aux_ff   <= aux_n;
                  last_ff  <= now_ff;
               end
               // The good frame count is pinned just above the ready level once
               // the link is up, then counts this frame as usual.
               if (armed_n && good_cnt_ff > READY_FRAMES) begin
                  ready_ff    <= 1'b1;
                  good_cnt_ff <= READY_FRAMES + 8'd2;
               end else begin
                  good_cnt_ff <= (good_cnt_ff == 8'hFF) ? 8'hFF : good_cnt_ff + 8'd1;
               end
               if (now_ff - sec_start_ff > SECOND_US) begin
                  fps_ff <= fts_ff; fts_ff <= 8'd1; sec_start_ff <= now_ff;
               end else begin
                  fts_ff <= (fts_ff == 8'hFF) ? 8'hFF : fts_ff + 8'd1;
               end
               fstate_ff <= 2'd3;
            end
            ST_RESP: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.frame_done   <= done_ff;
               rsp_ff.roll         <= roll_ff;
               rsp_ff.pitch        <= pitch_ff;
               rsp_ff.yaw          <= yaw_ff;
               rsp_ff.throttle     <= thr_ff;
               rsp_ff.aux_switches <= aux_ff;
               rsp_ff.failsafe     <= (now_ff - last_ff > noframe_lim_ff) | sl_flag_ff | sbfs_ff;
               rsp_ff.normal_mode  <= armed_ff;
               rsp_ff.link_up      <= ready_ff;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- sv/sbus_checker.sv -----
// Port-level checker for the SBUS gap-framed decoder, bound to its top level.
// Depends on sbus_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbus_checker
   import sbus_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   // No request is taken while a response waits in the output register.
   a_no_req_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
      else $error("request accepted while response stalled");
   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response changed while stalled");
   // Once armed, normal mode stays set.
   a_armed_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.normal_mode |=> !rsp_valid || rsp_data.normal_mode)
      else $error("normal mode dropped");
   // Link-up flag only with normal mode.
   a_ready_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.link_up |-> rsp_data.normal_mode)
      else $error("link up without normal mode");
endmodule

bind sbus_gap_framed_decoder sbus_checker u_sbus_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
`default_nettype wire

// ----- tb/sbus_gap_framed_decoder_checker.sv -----
// Response checker for the SBUS gap-framed decoder: follows every accepted request,
// register write and response, predicts each response and compares it field by field.
// Depends on sbus_pkg for the payload types, register indexes and constants.
`timescale 1ns / 1ps
`default_nettype none
module sbus_gap_framed_decoder_checker
   import sbus_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire req_type              req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire rsp_type              rsp_data,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata,
   output int                        pending,
   output int                        errors
);
   typedef enum logic [1:0] {FR_WAIT = 2'd0, FR_READY = 2'd1, FR_DONE = 2'd3} frame_phase_type;

   // Register copies.
   logic [15:0] gap_thr;
   logic [5:0]  frame_len;
   logic [31:0] siglost_lim, noframe_lim;
   logic [10:0] low_level, switch_level;
   logic [7:0]  arm_limit;

   // Decoder state.
   logic [7:0]      ring [64];
   logic [5:0]      wr_ptr, start_ptr;
   int              since_start, arm_count, good_frames, frames_now, fps;
   frame_phase_type phase;
   logic [31:0]     siglost_since, second_start, last_frame;
   logic            siglost, sbus_fs, armed, ready_latch;
   logic [11:0]     hold_roll, hold_pitch, hold_yaw;
   logic [10:0]     hold_throttle;
   logic [5:0]      hold_aux;

   rsp_type expected_q [$];
   rsp_type want;

   function automatic int sat_up(int v);
      return (v < 255) ? v + 1 : 255;
   endfunction

   task automatic decode_frame(input logic [31:0] now);
      logic [7:0]   d [FRAME_BYTES];
      logic [175:0] bits;
      logic [10:0]  ch [10];
      logic [5:0]   idx;
      int           t;
      for (int k = 0; k < FRAME_BYTES; k++) begin
         idx = start_ptr + 6'(k);
         d[k] = ring[idx];
      end
      if (d[23][2]) begin
         if (siglost_since == 32'd0) siglost_since = now;
         if ((now - siglost_since) > siglost_lim) siglost = 1'b1;
      end else begin
         siglost_since = 32'd0;
         siglost = 1'b0;
      end
      sbus_fs = d[23][3];
      // The channels are packed back to back, least significant bit first, from byte 1.
      for (int k = 1; k <= 22; k++) bits[(k-1)*8 +: 8] = d[k];
      for (int i = 0; i < 10; i++) ch[i] = bits[i*11 +: 11];

      if (!armed) begin
         if (ch[2] < low_level) arm_count = sat_up(arm_count);
         if (arm_count > int'(arm_limit)) begin
            if (fps > int'(MIN_FPS)) armed = 1'b1;
            else arm_count = 0;
         end
      end
      if (armed) begin
         hold_roll  = 12'(int'(ch[0]) - int'(STICK_CENTER));
         hold_pitch = 12'(int'(ch[1]) - int'(STICK_CENTER));
         hold_yaw   = 12'(int'(ch[3]) - int'(STICK_CENTER));
         t = int'(ch[2]) - int'(THROTTLE_LOW);
         if (t < 0) t = 0;
         if (t > int'(THROTTLE_MAX)) t = int'(THROTTLE_MAX);
         hold_throttle = 11'(t);
         for (int i = 0; i < 6; i++) hold_aux[i] = ch[4+i] > switch_level;
         last_frame = now;
         if (good_frames > int'(READY_FRAMES)) begin
            ready_latch = 1'b1;
            good_frames = int'(READY_FRAMES) + 1;
         end
      end
      if ((now - second_start) > SECOND_US) begin
         fps = frames_now;
         frames_now = 0;
         second_start = now;
      end
      frames_now = sat_up(frames_now);
      phase = FR_DONE;
      good_frames = sat_up(good_frames);
   endtask

   task automatic predict_response(input req_type r, output rsp_type e);
      logic [15:0] gap;
      logic        done;
      gap = r.gap_ticks;
      done = 1'b0;
      if (r.opcode == OP_BYTE) begin
         ring[wr_ptr] = r.rx_byte;
         if (r.overrun) gap = OVERRUN_GAP;
         since_start = sat_up(since_start);
         if (gap > gap_thr) begin
            start_ptr = wr_ptr;
            since_start = 0;
            phase = FR_WAIT;
         end else if (since_start >= int'(frame_len) && phase == FR_WAIT) begin
            phase = FR_READY;
         end
         wr_ptr = wr_ptr + 6'd1;
      end
      if (phase == FR_READY) begin
         decode_frame(r.now_us);
         done = 1'b1;
      end
      e.frame_done   = done;
      e.roll         = hold_roll;
      e.pitch        = hold_pitch;
      e.yaw          = hold_yaw;
      e.throttle     = hold_throttle;
      e.aux_switches = hold_aux;
      e.failsafe     = ((r.now_us - last_frame) > noframe_lim) | siglost | sbus_fs;
      e.normal_mode  = armed;
      e.link_up      = ready_latch;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         errors = errors + 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gap_thr = 16'd9000;
         frame_len = 6'd24;
         siglost_lim = 32'd1000000;
         noframe_lim = 32'd1000000;
         low_level = 11'd300;
         switch_level = 11'd1600;
         arm_limit = 8'd130;
         wr_ptr = '0; start_ptr = '0; since_start = 0; phase = FR_WAIT;
         siglost_since = '0; siglost = 1'b0; sbus_fs = 1'b0;
         arm_count = 0; armed = 1'b0; good_frames = 0;
         frames_now = 0; fps = 0; second_start = '0; last_frame = '0;
         hold_roll = '0; hold_pitch = '0; hold_yaw = '0;
         hold_throttle = '0; hold_aux = '0; ready_latch = 1'b0;
         expected_q.delete();
         pending <= 0;
         errors = 0;
      end else begin
         // A response can never belong to a request taken at the same edge,
         // so the response is matched before the new request is predicted.
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response with no request outstanding");
               errors = errors + 1;
            end else begin
               want = expected_q.pop_front();
               check_field("frame_done", want.frame_done, rsp_data.frame_done);
               check_field("roll", want.roll, rsp_data.roll);
               check_field("pitch", want.pitch, rsp_data.pitch);
               check_field("yaw", want.yaw, rsp_data.yaw);
               check_field("throttle", want.throttle, rsp_data.throttle);
               check_field("aux_switches", want.aux_switches, rsp_data.aux_switches);
               check_field("failsafe", want.failsafe, rsp_data.failsafe);
               check_field("normal_mode", want.normal_mode, rsp_data.normal_mode);
               check_field("link_up", want.link_up, rsp_data.link_up);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GAP_THRESHOLD: gap_thr = csr_wdata[15:0];
               REG_FRAME_LENGTH:  frame_len = csr_wdata[5:0];
               REG_SIGLOST_LIMIT: siglost_lim = csr_wdata;
               REG_NOFRAME_LIMIT: noframe_lim = csr_wdata;
               REG_LOW_THROTTLE:  low_level = csr_wdata[10:0];
               REG_SWITCH_THRESH: switch_level = csr_wdata[10:0];
               REG_ARM_FRAMES:    arm_limit = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_response(req_data, want);
            expected_q.push_back(want);
         end
         pending <= expected_q.size();
      end
   end
endmodule
`default_nettype wire

// ----- tb/sbus_gap_framed_decoder_tb.sv -----
// Top of the SBUS gap-framed decoder testbench: clock, reset, request, register and
// response stimulus, watchdog and verdict. Depends on sbus_pkg, the decoder and the checker.
`timescale 1ns / 1ps
`default_nettype none
module sbus_gap_framed_decoder_tb;
   import sbus_pkg::*;

   // No register lives at this index, so a write to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int STALL_LIMIT = 4000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid, req_ready;
   req_type              req_data;
   logic                 rsp_valid, rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;
   int                   pending, errors;

   // Stimulus controls shared with the response side. A hold-off is asked for
   // by toggling hold_off_tog; the response side notes the toggle itself.
   logic        idling_on;
   int          hold_off_len;
   logic        hold_off_tog;
   logic        hold_off_seen;
   int          hold_off_left;
   logic [31:0] clock_us;
   logic [15:0] cur_gap_thr;
   int          stall_cycles;

   sbus_gap_framed_decoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   sbus_gap_framed_decoder_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending(pending), .errors(errors)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The response side stalls now and then on its own, and when asked it holds off
   // for a long stretch so that the decoder fills up and pushes back on requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_off_left = 0;
         hold_off_seen = hold_off_tog;
      end else begin
         if (hold_off_seen != hold_off_tog) begin
            hold_off_seen = hold_off_tog;
            hold_off_left = hold_off_len;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !idling_on || ($urandom_range(99) >= 7);
         end
      end
   end

   // The watchdog counts cycles in which no channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("sbus_gap_framed_decoder test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offers one request and returns at the edge that accepts it. Valid is only
   // dropped for an idle gap, never in the step where it is raised again.
   task automatic offer_request(input req_type r);
      if (idling_on && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Register writes only happen once the decoder has answered everything and the last
   // response has left its output register; an extra wait follows before the write.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      wait_until_drained();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_GAP_THRESHOLD) cur_gap_thr = value[15:0];
   endtask

   task automatic send_byte(input logic [7:0] b, input logic [15:0] gap, input logic ovr);
      req_type r;
      clock_us = clock_us + $urandom_range(7000, 1000);
      r.opcode = OP_BYTE;
      r.rx_byte = b;
      r.gap_ticks = gap;
      r.overrun = ovr;
      r.now_us = clock_us;
      offer_request(r);
   endtask

   task automatic send_poll(input logic [31:0] now);
      req_type r;
      r.opcode = ~OP_BYTE;
      r.rx_byte = 8'($urandom);
      r.gap_ticks = 16'($urandom);
      r.overrun = 1'($urandom);
      r.now_us = now;
      offer_request(r);
   endtask

   // A well-formed frame: a start byte after a long gap, then body bytes with
   // short gaps. Content is random, so the flag byte and throttle vary too.
   task automatic send_frame(input int body);
      logic [15:0] short_gap;
      if (cur_gap_thr == 16'hFFFF) send_byte(8'($urandom), 16'hFFFF, 1'b1);
      else send_byte(8'($urandom), 16'($urandom_range(65535, cur_gap_thr + 1)),
                     $urandom_range(9) == 0);
      for (int k = 0; k < body; k++) begin
         short_gap = 16'($urandom_range(cur_gap_thr, 0));
         send_byte(8'($urandom), short_gap, 1'b0);
      end
   endtask

   task automatic run_phase(input int items, input int body_max);
      int sent;
      int body;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(19))
            0: begin
               send_poll(clock_us);
               sent++;
            end
            1: begin
               send_byte(8'($urandom), 16'($urandom), 1'($urandom));
               sent++;
            end
            2: begin
               // A time jump lets the no-frames timer run out or the clock wrap.
               clock_us = $urandom;
               send_poll(clock_us);
               sent++;
            end
            default: begin
               body = $urandom_range(body_max, 1);
               send_frame(body);
               sent += body + 1;
            end
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idling_on = 1'b1;
      hold_off_len = 0;
      hold_off_tog = 1'b0;
      clock_us = $urandom;
      cur_gap_thr = 16'd9000;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole byte ring with a long frame length set, so that no
      // decode ever reads an entry that has not been written since reset.
      write_register(REG_FRAME_LENGTH, 32'd63);
      for (int k = 0; k < 64; k++) send_byte(8'($urandom), 16'd0, 1'b0);

      // Directed part: extremes of each field, polls, overrun, long gaps, the
      // frame-length-zero case, time at zero and at the top of its range.
      write_register(REG_GAP_THRESHOLD, 32'd100);
      write_register(REG_FRAME_LENGTH, 32'd0);
      write_register(REG_SIGLOST_LIMIT, 32'd0);
      write_register(REG_NOFRAME_LIMIT, 32'hFFFF_FFFF);
      write_register(REG_LOW_THROTTLE, 32'd2047);
      write_register(REG_SWITCH_THRESH, 32'd0);
      write_register(REG_ARM_FRAMES, 32'd0);
      write_register(REG_UNUSED, 32'hFFFF_FFFF);
      send_poll(32'd0);
      send_poll(32'hFFFF_FFFF);
      send_byte(8'hFF, 16'hFFFF, 1'b0);
      send_byte(8'h00, 16'd0, 1'b0);
      send_byte(8'h00, 16'd0, 1'b1);
      send_byte(8'hFF, 16'd0, 1'b0);
      send_byte(8'h0C, 16'd101, 1'b0);
      send_byte(8'h55, 16'd100, 1'b0);
      write_register(REG_FRAME_LENGTH, 32'd1);
      for (int k = 0; k < 8; k++) send_frame(1);
      send_poll(32'd0);

      // Random phases, each with its own register setting.
      for (int p = 0; p < 6; p++) begin
         idling_on = (p != 1);
         case (p)
            0: begin
               write_register(REG_GAP_THRESHOLD, 32'd9000);
               write_register(REG_NOFRAME_LIMIT, 32'd1000000);
               write_register(REG_SIGLOST_LIMIT, $urandom_range(200000));
               write_register(REG_SWITCH_THRESH, 32'd1600);
            end
            1: begin
               write_register(REG_GAP_THRESHOLD, 32'd0);
               write_register(REG_FRAME_LENGTH, 32'd24);
               write_register(REG_SIGLOST_LIMIT, 32'd0);
               write_register(REG_NOFRAME_LIMIT, 32'd0);
               write_register(REG_LOW_THROTTLE, 32'd0);
               write_register(REG_SWITCH_THRESH, 32'd0);
               write_register(REG_ARM_FRAMES, 32'd255);
            end
            2: begin
               write_register(REG_GAP_THRESHOLD, 32'd65535);
               write_register(REG_FRAME_LENGTH, 32'd63);
               write_register(REG_SIGLOST_LIMIT, 32'hFFFF_FFFF);
               write_register(REG_NOFRAME_LIMIT, 32'hFFFF_FFFF);
               write_register(REG_LOW_THROTTLE, 32'd300);
               write_register(REG_SWITCH_THRESH, 32'd2047);
               write_register(REG_ARM_FRAMES, 32'd130);
            end
            default: begin
               write_register(REG_GAP_THRESHOLD, $urandom_range(60000));
               write_register(REG_FRAME_LENGTH, $urandom_range(6));
               write_register(REG_SIGLOST_LIMIT, $urandom_range(3000000));
               write_register(REG_NOFRAME_LIMIT, $urandom_range(3000000));
               write_register(REG_LOW_THROTTLE, $urandom_range(2047));
               write_register(REG_SWITCH_THRESH, $urandom_range(2047));
               write_register(REG_ARM_FRAMES, $urandom_range(10));
            end
         endcase
         if (p == 3) begin
            // Long hold-off on the response side while requests keep coming.
            hold_off_len = 300;
            hold_off_tog = ~hold_off_tog;
         end
         if (p == 2) begin
            // With the gap threshold at its top no frame can start: the byte
            // counter runs up to saturation instead.
            for (int k = 0; k < 270; k++)
               send_byte(8'($urandom), 16'($urandom), 1'($urandom));
         end else begin
            run_phase(70, (p == 1) ? 24 : 6);
            wait_until_drained();
            run_phase(70, (p == 1) ? 24 : 6);
         end
      end

      wait_until_drained();
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("sbus_gap_framed_decoder test passed");
      end else begin
         $display("sbus_gap_framed_decoder test failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
